// ===== hw/rtl/tsbs_pkg.sv =====
// Shared widths, codes and types for the sorted timestamp search block.
`timescale 1ns / 1ps

package tsbs_pkg;

    localparam int unsigned STAMP_W     = 64;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned LOC_W       = 11;
    localparam int unsigned SUM_W       = LOC_W + 1;
    localparam int unsigned TABLE_DEPTH = 1024;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [LOC_W-1:0] location;
    } t_result;

endpackage

// ===== hw/rtl/tsbs_mem.sv =====
// Timestamp table: one write port and one registered read port.
`timescale 1ns / 1ps

module tsbs_mem #(
    parameter int unsigned DEPTH = tsbs_pkg::TABLE_DEPTH,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [tsbs_pkg::STAMP_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [tsbs_pkg::STAMP_W-1:0] o_rd_data
);

    logic [tsbs_pkg::STAMP_W-1:0] r_table [DEPTH];
    logic [tsbs_pkg::STAMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_table[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_table[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/tsbs_ctrl.sv =====
// Search sequencer: issues table reads, narrows the bounds and forms the result.
`timescale 1ns / 1ps

module tsbs_ctrl #(
    parameter int unsigned DEPTH = tsbs_pkg::TABLE_DEPTH,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_func,
    input  logic [tsbs_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [tsbs_pkg::STAMP_W-1:0] i_stamp,
    input  logic [tsbs_pkg::LOC_W-1:0]          i_entry_count,
    output logic                                o_busy,
    output logic                                o_wr_en,
    output logic [AW-1:0]                       o_wr_addr,
    output logic                                o_rd_en,
    output logic [AW-1:0]                       o_rd_addr,
    input  logic [tsbs_pkg::STAMP_W-1:0]        i_rd_data,
    output tsbs_pkg::t_result                   o_result
);

    localparam int unsigned LOC_MAX = (1 << tsbs_pkg::LOC_W) - 1;
    localparam int unsigned CLAMP   = (DEPTH < LOC_MAX) ? DEPTH : LOC_MAX;
    localparam logic [tsbs_pkg::LOC_W-1:0] CLAMP_V = tsbs_pkg::LOC_W'(CLAMP);

    tsbs_pkg::t_state r_state, n_state;
    logic [tsbs_pkg::LOC_W-1:0] r_lo, n_lo;
    logic [tsbs_pkg::LOC_W-1:0] r_hi_ex, n_hi_ex;
    logic [tsbs_pkg::LOC_W-1:0] r_mid, n_mid;
    logic signed [tsbs_pkg::STAMP_W-1:0] r_key, n_key;
    tsbs_pkg::t_result r_result, n_result;

    logic                       accept;
    logic [tsbs_pkg::LOC_W-1:0] count;
    logic [tsbs_pkg::LOC_W-1:0] step_lo;
    logic [tsbs_pkg::LOC_W-1:0] step_hi_ex;
    logic [tsbs_pkg::SUM_W-1:0] mid_sum;
    logic signed [tsbs_pkg::STAMP_W-1:0] probe;

    assign accept = i_start && (r_state == tsbs_pkg::ST_IDLE);
    assign count  = (i_entry_count > CLAMP_V) ? CLAMP_V : i_entry_count;
    assign probe  = $signed(i_rd_data);

    assign o_wr_en   = accept && (i_func == tsbs_pkg::FUNC_WRITE)
                       && (32'(i_entry_index) < 32'(DEPTH));
    assign o_wr_addr = AW'(i_entry_index);

    // Bounds are kept as [lo, hi_ex): the range is empty once lo reaches hi_ex.
    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi_ex  = r_hi_ex;
        n_mid    = r_mid;
        n_key    = r_key;
        n_result = r_result;
        n_result.valid = 1'b0;
        o_rd_en  = 1'b0;
        step_lo    = r_lo;
        step_hi_ex = r_hi_ex;
        mid_sum    = '0;

        case (r_state)
            tsbs_pkg::ST_IDLE: begin
                if (accept && (i_func == tsbs_pkg::FUNC_SEARCH)) begin
                    n_key   = i_stamp;
                    n_lo    = '0;
                    n_hi_ex = count;
                    if (count == '0) begin
                        n_result.valid    = 1'b1;
                        n_result.found    = 1'b0;
                        n_result.location = '0;
                    end else begin
                        mid_sum = {1'b0, count} - tsbs_pkg::SUM_W'(1);
                        n_mid   = mid_sum[tsbs_pkg::SUM_W-1:1];
                        o_rd_en = 1'b1;
                        n_state = tsbs_pkg::ST_SEARCH;
                    end
                end
            end
            tsbs_pkg::ST_SEARCH: begin
                if (probe == r_key) begin
                    n_result.valid    = 1'b1;
                    n_result.found    = 1'b1;
                    n_result.location = r_mid;
                    n_state           = tsbs_pkg::ST_IDLE;
                end else begin
                    if (r_key < probe) begin
                        step_hi_ex = r_mid;
                    end else begin
                        step_lo = r_mid + tsbs_pkg::LOC_W'(1);
                    end
                    n_lo    = step_lo;
                    n_hi_ex = step_hi_ex;
                    if (step_lo < step_hi_ex) begin
                        mid_sum = {1'b0, step_lo} + {1'b0, step_hi_ex}
                                  - tsbs_pkg::SUM_W'(1);
                        n_mid   = mid_sum[tsbs_pkg::SUM_W-1:1];
                        o_rd_en = 1'b1;
                    end else begin
                        n_result.valid    = 1'b1;
                        n_result.found    = 1'b0;
                        n_result.location = step_lo;
                        n_state           = tsbs_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tsbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr = AW'(n_mid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tsbs_pkg::ST_IDLE;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi_ex <= n_hi_ex;
        r_mid   <= n_mid;
        r_key   <= n_key;
    end

    assign o_busy   = (r_state != tsbs_pkg::ST_IDLE);
    assign o_result = r_result;

endmodule

// ===== hw/rtl/sorted_timestamp_binary_search.sv =====
// Top level of the sorted timestamp table with lower-bound binary search.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  command  | start in, busy out        | i_func, i_entry_index, i_stamp
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_data (entry_count)
//  result   | o_result_valid strobe     | o_found, o_location
//
// A write beat gives no result. A search makes P table probes, where P is at most
// ceil(log2(count + 1)); the registered table read and 64-bit compare form one
// probe per cycle. An empty table answers in the next cycle, without a probe.
// Synchronous reset clears the sequencer and the entry count; table contents
// are undefined until written. The result is shown for one cycle and cannot
// be held off.
`timescale 1ns / 1ps

module sorted_timestamp_binary_search #(
    parameter int unsigned TABLE_DEPTH = tsbs_pkg::TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [tsbs_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [tsbs_pkg::STAMP_W-1:0] i_stamp,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tsbs_pkg::LOC_W-1:0]          i_cfg_data,
    output logic                                o_result_valid,
    output logic                                o_found,
    output logic [tsbs_pkg::LOC_W-1:0]          o_location
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    logic [tsbs_pkg::LOC_W-1:0]   r_entry_count;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [tsbs_pkg::STAMP_W-1:0] rd_data;
    tsbs_pkg::t_result            result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entry_count <= i_cfg_data;
        end
    end

    tsbs_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_func        (i_func),
        .i_entry_index (i_entry_index),
        .i_stamp       (i_stamp),
        .i_entry_count (r_entry_count),
        .o_busy        (busy),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_result      (result)
    );

    tsbs_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_stamp),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_result_valid = result.valid;
    assign o_found        = result.found;
    assign o_location     = result.location;

`ifndef NO_ASSERTIONS
    // A match always lies inside the populated part of the table.
    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_found) |-> (o_location < r_entry_count))
        else $error("match location beyond entry count");

    // An insertion position never exceeds the entry count.
    a_insert_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> (o_location <= r_entry_count))
        else $error("insertion position beyond entry count");

    // The sequencer only becomes busy after accepting a search beat.
    a_busy_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_func == tsbs_pkg::FUNC_SEARCH)))
        else $error("busy without a search beat");

    // No table read is issued once the sequencer is idle and not starting.
    a_read_only_searching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (busy || (start && (i_func == tsbs_pkg::FUNC_SEARCH))))
        else $error("table read outside a search");
`endif

endmodule

// ===== verif/sorted_timestamp_binary_search_tb.sv =====
// Self-checking testbench for the sorted timestamp table with lower-bound binary search.
`timescale 1ns / 1ps

module sorted_timestamp_binary_search_tb;

    typedef struct {
        logic                       found;
        logic [tsbs_pkg::LOC_W-1:0] location;
    } t_search_answer;

    localparam logic signed [tsbs_pkg::STAMP_W-1:0] STAMP_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [tsbs_pkg::STAMP_W-1:0] STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int MAX_REPORTS = 100;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                start         = 1'b0;
    logic                                i_func        = tsbs_pkg::FUNC_WRITE;
    logic [tsbs_pkg::IDX_W-1:0]          i_entry_index = '0;
    logic signed [tsbs_pkg::STAMP_W-1:0] i_stamp       = '0;
    logic                                i_cfg_valid   = 1'b0;
    logic [tsbs_pkg::LOC_W-1:0]          i_cfg_data    = '0;
    logic                                busy;
    logic                                o_cfg_ready;
    logic                                o_result_valid;
    logic                                o_found;
    logic [tsbs_pkg::LOC_W-1:0]          o_location;

    // Shadow copy of the table and the count register, updated at each accepted beat.
    logic signed [tsbs_pkg::STAMP_W-1:0] table_copy [tsbs_pkg::TABLE_DEPTH];
    logic [tsbs_pkg::LOC_W-1:0]          entry_count_copy = '0;
    t_search_answer                      search_answers [$];
    int                                  mismatch_count = 0;
    int                                  burst_left = 0;

    sorted_timestamp_binary_search dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_entry_index  (i_entry_index),
        .i_stamp        (i_stamp),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_location     (o_location)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int active_entries();
        return (entry_count_copy > tsbs_pkg::TABLE_DEPTH) ? tsbs_pkg::TABLE_DEPTH
                                                          : int'(entry_count_copy);
    endfunction

    function automatic logic signed [tsbs_pkg::STAMP_W-1:0] random_stamp();
        return $signed({$urandom, $urandom});
    endfunction

    function automatic logic signed [tsbs_pkg::STAMP_W-1:0] extreme_stamp();
        case ($urandom_range(0, 3))
            0:       return STAMP_MIN;
            1:       return STAMP_MAX;
            2:       return STAMP_MIN + 1;
            default: return STAMP_MAX - 1;
        endcase
    endfunction

    // Probe order follows the block exactly, so an unsorted table still predicts bit for bit.
    function automatic t_search_answer lower_bound_search(
            input logic signed [tsbs_pkg::STAMP_W-1:0] key);
        t_search_answer answer;
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = active_entries() - 1;
        answer.found = 1'b0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (table_copy[mid] == key) begin
                answer.found    = 1'b1;
                answer.location = tsbs_pkg::LOC_W'(mid);
                return answer;
            end
            if (key < table_copy[mid]) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        answer.location = tsbs_pkg::LOC_W'(lo);
        return answer;
    endfunction

    // Sends one command beat; start stays high on return so the next beat can follow at once.
    task automatic send_command(input logic func, input logic [tsbs_pkg::IDX_W-1:0] slot,
                                input logic signed [tsbs_pkg::STAMP_W-1:0] value);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        start         <= 1'b1;
        i_func        <= func;
        i_entry_index <= slot;
        i_stamp       <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (func == tsbs_pkg::FUNC_WRITE) begin
            table_copy[slot] = value;
        end else begin
            search_answers.push_back(lower_bound_search(value));
        end
    endtask

    task automatic wait_for_idle();
        start <= 1'b0;
        while (search_answers.size() != 0) @(posedge i_clk);
        // A write beat gives no result, so allow for one still in flight.
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input logic [tsbs_pkg::LOC_W-1:0] value);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        entry_count_copy = value;
    endtask

    // Writes slots 0 to n-1 with strictly increasing values, optionally pinned to both extremes.
    task automatic fill_sorted(input int n, input bit with_extremes);
        logic signed [tsbs_pkg::STAMP_W-1:0] next_value;
        next_value = random_stamp() >>> 3;
        for (int s = 0; s < n; s++) begin
            if (with_extremes && s == 0) begin
                send_command(tsbs_pkg::FUNC_WRITE, tsbs_pkg::IDX_W'(s), STAMP_MIN);
            end else if (with_extremes && s == n - 1) begin
                send_command(tsbs_pkg::FUNC_WRITE, tsbs_pkg::IDX_W'(s), STAMP_MAX);
            end else begin
                send_command(tsbs_pkg::FUNC_WRITE, tsbs_pkg::IDX_W'(s), next_value);
            end
            next_value = next_value + 64'(1)
                + (64'($urandom >> $urandom_range(0, 31)) << $urandom_range(0, 16));
        end
    endtask

    // Mostly searches aimed at stored keys and their neighbors, with writes mixed in.
    // Without scrambling, writes land only above the active entries.
    task automatic run_traffic(input int n_items, input bit scramble);
        int                                  active;
        int                                  pick;
        logic [tsbs_pkg::IDX_W-1:0]          slot;
        logic signed [tsbs_pkg::STAMP_W-1:0] key;
        for (int i = 0; i < n_items; i++) begin
            active = active_entries();
            slot   = tsbs_pkg::IDX_W'($urandom);
            if ($urandom_range(0, 99) < (scramble ? 30 : 15)
                    && (scramble || active < tsbs_pkg::TABLE_DEPTH)) begin
                if (!scramble) begin
                    slot = tsbs_pkg::IDX_W'($urandom_range(active,
                                                           tsbs_pkg::TABLE_DEPTH - 1));
                end
                send_command(tsbs_pkg::FUNC_WRITE, slot, random_stamp());
            end else begin
                pick = $urandom_range(0, 9);
                if (active > 0 && pick < 4) begin
                    key = table_copy[$urandom_range(0, active - 1)];
                end else if (active > 0 && pick < 6) begin
                    key = table_copy[$urandom_range(0, active - 1)] + ((pick == 4) ? 1 : -1);
                end else if (pick == 6) begin
                    key = extreme_stamp();
                end else begin
                    key = random_stamp();
                end
                send_command(tsbs_pkg::FUNC_SEARCH, slot, key);
            end
        end
    endtask

    task automatic test_empty_table();
        send_command(tsbs_pkg::FUNC_SEARCH, '0, STAMP_MIN);
        send_command(tsbs_pkg::FUNC_SEARCH, '1, STAMP_MAX);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, '0);
    endtask

    task automatic test_extreme_entries();
        send_command(tsbs_pkg::FUNC_WRITE, 10'd0, STAMP_MIN);
        send_command(tsbs_pkg::FUNC_WRITE, 10'd1, -64'sd1000);
        send_command(tsbs_pkg::FUNC_WRITE, 10'd2, -64'sd1);
        send_command(tsbs_pkg::FUNC_WRITE, 10'd3, 64'sd0);
        send_command(tsbs_pkg::FUNC_WRITE, 10'd4, 64'sd1);
        send_command(tsbs_pkg::FUNC_WRITE, 10'd5, 64'sd1000);
        send_command(tsbs_pkg::FUNC_WRITE, 10'd6, 64'sh4000_0000_0000_0000);
        send_command(tsbs_pkg::FUNC_WRITE, 10'd7, STAMP_MAX);
        send_command(tsbs_pkg::FUNC_WRITE, '1, 64'sh5555_5555_5555_5555);
        set_entry_count(11'd8);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, STAMP_MIN);
        send_command(tsbs_pkg::FUNC_SEARCH, '1, STAMP_MAX);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, 64'sd0);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, -64'sd2);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, 64'sd2);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, STAMP_MAX - 1);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, STAMP_MIN + 1);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, 64'sh4000_0000_0000_0001);
        set_entry_count(11'd1);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, STAMP_MIN);
        send_command(tsbs_pkg::FUNC_SEARCH, '0, 64'sd5);
    endtask

    task automatic test_sorted_search();
        int n;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       n = 2;
                1:       n = 3;
                2, 3, 4: n = $urandom_range(1, 16);
                5, 6, 7: n = $urandom_range(17, 64);
                default: n = $urandom_range(65, 128);
            endcase
            fill_sorted(n, (p % 2) == 1);
            set_entry_count(tsbs_pkg::LOC_W'(n));
            run_traffic(12, 1'b0);
        end
    endtask

    // Full table, counts past the table depth, and an empty count over a written table.
    task automatic test_full_table();
        fill_sorted(tsbs_pkg::TABLE_DEPTH, 1'b1);
        set_entry_count(11'd1024);
        run_traffic(40, 1'b0);
        set_entry_count(11'd2047);
        run_traffic(30, 1'b0);
        set_entry_count(11'd1500);
        run_traffic(15, 1'b0);
        set_entry_count(11'd0);
        run_traffic(15, 1'b0);
    endtask

    task automatic test_unsorted_table();
        int n;
        n = $urandom_range(32, 64);
        fill_sorted(n, 1'b0);
        set_entry_count(tsbs_pkg::LOC_W'(n));
        run_traffic(60, 1'b1);
    endtask

    always @(posedge i_clk) begin
        t_search_answer want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (search_answers.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected, found %0b location %0d",
                         $time, o_found, o_location);
            end else begin
                want = search_answers.pop_front();
                if (o_found !== want.found || o_location !== want.location) begin
                    mismatch_count++;
                    // Keep the log readable when the block is badly broken.
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"%0t: expected found %0b location %0d, ",
                                  "actual found %0b location %0d"},
                                 $time, want.found, want.location, o_found, o_location);
                    end
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_empty_table();
        test_extreme_entries();
        test_sorted_search();
        test_full_table();
        test_unsorted_table();
        wait_for_idle();
        if (mismatch_count == 0 && search_answers.size() == 0) begin
            $display("sorted_timestamp_binary_search verification clean");
        end else begin
            $display("sorted_timestamp_binary_search verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("sorted_timestamp_binary_search verification failed");
        $finish;
    end

endmodule
